// ----- hw/rtl/iorb_pkg.sv -----
// shared types and constants for the in-order release reorder buffer
// no dependencies; imported by the top level

package iorb_pkg;

  // default sizing
  localparam int unsigned WINDOW_DEF   = 32;
  localparam int unsigned SEQ_BITS_DEF = 16;
  localparam int unsigned TAG_BITS_DEF = 16;

  // fixed port field widths
  localparam int unsigned SEQ_PORT_W = 16;
  localparam int unsigned TAG_PORT_W = 16;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_RELEASED = 2'd0,
    STATUS_OLD      = 2'd1,
    STATUS_BEYOND   = 2'd2,
    STATUS_DONE     = 2'd3
  } status_e;

  // control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN
  } state_e;

endpackage

// ----- hw/rtl/in_order_release_reorder_buffer.sv -----
// top level of the in-order release reorder buffer
// depends on iorb_pkg and iorb_ram

// Takes numbered words (sequence number, payload tag, final flag on tlast)
// and releases them strictly in sequence order. A word at the expected
// number is released at once, followed by every consecutive held word as
// one run; tlast marks the last result of that run. Early words within
// WINDOW of the expected number are parked in a tag ram and give no
// result; a repeated number overwrites the parked tag. Old words, words
// beyond the window and anything after the final number was released are
// dropped with one status result (tuser). A word is captured in ST_IDLE
// and classified in the next cycle in ST_EVAL; a release run gives one
// result per cycle while the output register is free, paced by the single
// read port of the tag ram that fetches the next head slot while the
// current result is loaded. Results leave through an output register, and
// a new word is accepted while a result still waits there. Slot valid bits
// are flip-flops cleared at reset and on a cfg write, so there is no
// clearing pass. A cfg write (new first sequence number) restarts the
// block and must only be issued while idle.

module in_order_release_reorder_buffer
  import iorb_pkg::*;
#(
  parameter int unsigned WINDOW   = WINDOW_DEF,
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF,
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration: first sequence number
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,

  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // seq_number[15:0], payload_tag[31:16]
  input  logic        s_axis_tlast,   // is_final

  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_seq[15:0], out_tag[31:16],
                                      // stream_done[32], zero fill[39:33]
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast    // run_end
);

  localparam int unsigned PW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  // stored tag never needs more than the port carries
  localparam int unsigned TW = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;

  // control state
  state_e              state_q, state_d;
  logic [SEQ_BITS-1:0] expected_q, expected_d;
  logic [WINDOW-1:0]   slot_valid_q, slot_valid_d;
  logic [PW-1:0]       head_q, head_d;
  logic                final_known_q, final_known_d;
  logic [SEQ_BITS-1:0] final_seq_q, final_seq_d;
  logic                done_q, done_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  // captured input word
  logic [SEQ_BITS-1:0] seq_q, seq_d;
  logic [TW-1:0]       tag_q, tag_d;
  logic                fin_q, fin_d;

  // output register payload
  status_e             out_status_q, out_status_d;
  logic [15:0]         out_seq_q, out_seq_d;
  logic [15:0]         out_tag_q, out_tag_d;
  logic                out_done_q, out_done_d;
  logic                out_last_q, out_last_d;
  logic                load;

  // tag ram
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [TW-1:0]       ram_rdata;

  // classification of the captured word
  logic [SEQ_BITS-1:0] seq_gap;
  logic                is_match, is_old, is_beyond;
  logic [PW:0]         slot_sum;
  logic [PW-1:0]       slot_idx;
  logic [PW-1:0]       head_inc;

  // release of the word at the expected number
  logic                in_accept, cfg_accept, out_free;
  logic [TW-1:0]       rel_tag;
  logic                rel_fk;
  logic [SEQ_BITS-1:0] rel_fs;
  logic                rel_done;
  logic [CW-1:0]       cnt_next;
  logic                more;

  assign cfg_ready_o   = 1'b1;
  assign cfg_accept    = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  // output register can take a word this cycle
  assign out_free      = ~out_valid_q | m_axis_tready;

  assign seq_gap   = seq_q - expected_q;
  assign is_match  = (seq_gap == '0);
  assign is_old    = seq_gap[SEQ_BITS-1];
  assign is_beyond = (32'(seq_gap) >= 32'(WINDOW));

  // held words have a gap below WINDOW, so one subtract wraps the slot
  assign slot_sum = {1'b0, head_q} + (PW+1)'(seq_gap);
  assign slot_idx = (slot_sum >= (PW+1)'(WINDOW)) ? PW'(slot_sum - (PW+1)'(WINDOW))
                                                 : PW'(slot_sum);
  assign head_inc = (head_q == PW'(WINDOW - 1)) ? '0 : head_q + 1'b1;

  // first release of a run uses the captured tag, the rest come from ram
  assign rel_tag  = (state_q == ST_EVAL) ? tag_q : ram_rdata;
  assign rel_fk   = final_known_q | ((state_q == ST_EVAL) & fin_q);
  assign rel_fs   = ((state_q == ST_EVAL) & fin_q) ? seq_q : final_seq_q;
  assign rel_done = done_q | (rel_fk & (expected_q == rel_fs));
  assign cnt_next = (state_q == ST_EVAL) ? CW'(1) : cnt_q + 1'b1;
  assign more     = ~rel_done & slot_valid_q[head_inc] & (cnt_next < CW'(WINDOW));

  always_comb begin
    state_d       = state_q;
    expected_d    = expected_q;
    slot_valid_d  = slot_valid_q;
    head_d        = head_q;
    final_known_d = final_known_q;
    final_seq_d   = final_seq_q;
    done_d        = done_q;
    cnt_d         = cnt_q;
    seq_d         = seq_q;
    tag_d         = tag_q;
    fin_d         = fin_q;
    out_status_d  = out_status_q;
    out_seq_d     = out_seq_q;
    out_tag_d     = out_tag_q;
    out_done_d    = out_done_q;
    out_last_d    = out_last_q;
    load          = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_idx;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          seq_d   = SEQ_BITS'(s_axis_tdata[15:0]);
          tag_d   = TW'(s_axis_tdata[31:16]);
          fin_d   = s_axis_tlast;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (done_q || (!is_match && (is_old || is_beyond))) begin
          // drop with a single status word
          if (out_free) begin
            load         = 1'b1;
            out_status_d = done_q ? STATUS_DONE : (is_old ? STATUS_OLD : STATUS_BEYOND);
            out_seq_d    = 16'(seq_q);
            out_tag_d    = 16'(tag_q);
            out_done_d   = done_q;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (is_match) begin
          if (out_free) begin
            load          = 1'b1;
            out_status_d  = STATUS_RELEASED;
            out_seq_d     = 16'(expected_q);
            out_tag_d     = 16'(rel_tag);
            out_done_d    = rel_done;
            out_last_d    = ~more;
            final_known_d = rel_fk;
            final_seq_d   = rel_fs;
            done_d        = rel_done;
            slot_valid_d[head_q] = 1'b0;
            head_d        = head_inc;
            expected_d    = expected_q + 1'b1;
            cnt_d         = cnt_next;
            state_d       = more ? ST_DRAIN : ST_IDLE;
          end
        end else begin
          // park early word; slot is never the head, so no clash with the
          // head read issued in the same cycle
          ram_we                 = 1'b1;
          slot_valid_d[slot_idx] = 1'b1;
          if (fin_q) begin
            final_known_d = 1'b1;
            final_seq_d   = seq_q;
          end
          state_d = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        if (out_free) begin
          load          = 1'b1;
          out_status_d  = STATUS_RELEASED;
          out_seq_d     = 16'(expected_q);
          out_tag_d     = 16'(rel_tag);
          out_done_d    = rel_done;
          out_last_d    = ~more;
          done_d        = rel_done;
          slot_valid_d[head_q] = 1'b0;
          head_d        = head_inc;
          expected_d    = expected_q + 1'b1;
          cnt_d         = cnt_next;
          state_d       = more ? ST_DRAIN : ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // restart from a new first sequence number
    if (cfg_accept) begin
      expected_d    = SEQ_BITS'(cfg_data_i);
      slot_valid_d  = '0;
      head_d        = '0;
      final_known_d = 1'b0;
      final_seq_d   = '0;
      done_d        = 1'b0;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      expected_q    <= '0;
      slot_valid_q  <= '0;
      head_q        <= '0;
      final_known_q <= 1'b0;
      final_seq_q   <= '0;
      done_q        <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      expected_q    <= expected_d;
      slot_valid_q  <= slot_valid_d;
      head_q        <= head_d;
      final_known_q <= final_known_d;
      final_seq_q   <= final_seq_d;
      done_q        <= done_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    tag_q        <= tag_d;
    fin_q        <= fin_d;
    out_status_q <= out_status_d;
    out_seq_q    <= out_seq_d;
    out_tag_q    <= out_tag_d;
    out_done_q   <= out_done_d;
    out_last_q   <= out_last_d;
  end

  // read address follows the next head, so read data always holds the
  // tag of the current head slot
  iorb_ram #(
    .WIDTH (TW),
    .DEPTH (WINDOW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tag_q),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_done_q, out_tag_q, out_seq_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  // a release word that is not the end of its run must continue the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (out_status_d == STATUS_RELEASED) && !out_last_d |=> state_q == ST_DRAIN)
    else $error("release run ended without tlast");

  // every release advances the expected number by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (out_status_d == STATUS_RELEASED) && !cfg_accept
    |=> expected_q == SEQ_BITS'($past(expected_q) + 1'b1))
    else $error("expected number did not advance on release");

  // while the stream is open the head slot is empty between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && !done_q |-> !slot_valid_q[head_q])
    else $error("held word left at head slot");

  // done stays set until a restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !cfg_accept |=> done_q)
    else $error("done flag cleared without restart");

  // head pointer stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < 32'(WINDOW))
    else $error("head pointer out of range");
`endif

endmodule

// ----- hw/rtl/iorb_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies

module iorb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
